// ===== design/rcp_pkg.sv =====
package rcp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_TEST,
    S_SCAN,
    S_COMPACT,
    S_APPEND_TOP,
    S_APPEND_RIGHT,
    S_FINISH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load_in;
    logic    cand_rd_point;
    logic    load_point;
    logic    scan_start;
    logic    scan_step;
    logic    rect_write;
    logic    comp_start;
    logic    comp_step;
    logic    append_top;
    logic    append_right;
    logic    finish;
    status_t fin_status;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic bad_index;
    logic full;
    logic overflow;
    logic hit;
    logic scan_done;
    logic comp_done;
  } stat_t;

endpackage

// ===== design/rcp_ram.sv =====
module rcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rcp_ctrl.sv =====
module rcp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rcp_pkg::stat_t stat,
  output rcp_pkg::cmd_t  cmd,
  output logic           busy
);

  rcp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.fin_status = rcp_pkg::ST_PLACED;
    busy           = (state != rcp_pkg::S_IDLE);
    unique case (state)
      rcp_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = rcp_pkg::S_CHECK;
        end
      end
      rcp_pkg::S_CHECK: begin
        if (stat.bad_index) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rcp_pkg::ST_BAD_INDEX;
          state_next     = rcp_pkg::S_IDLE;
        end else begin
          cmd.cand_rd_point = 1'b1;
          state_next        = rcp_pkg::S_LOAD;
        end
      end
      rcp_pkg::S_LOAD: begin
        cmd.load_point = 1'b1;
        state_next     = rcp_pkg::S_TEST;
      end
      rcp_pkg::S_TEST: begin
        if (stat.full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rcp_pkg::ST_FULL;
          state_next     = rcp_pkg::S_IDLE;
        end else if (stat.overflow) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rcp_pkg::ST_OVERFLOW;
          state_next     = rcp_pkg::S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = rcp_pkg::S_SCAN;
        end
      end
      rcp_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rcp_pkg::ST_OVERLAP;
          state_next     = rcp_pkg::S_IDLE;
        end else if (stat.scan_done) begin
          cmd.rect_write = 1'b1;
          cmd.comp_start = 1'b1;
          state_next     = rcp_pkg::S_COMPACT;
        end
      end
      rcp_pkg::S_COMPACT: begin
        cmd.comp_step = 1'b1;
        if (stat.comp_done) begin
          state_next = rcp_pkg::S_APPEND_TOP;
        end
      end
      rcp_pkg::S_APPEND_TOP: begin
        cmd.append_top = 1'b1;
        state_next     = rcp_pkg::S_APPEND_RIGHT;
      end
      rcp_pkg::S_APPEND_RIGHT: begin
        cmd.append_right = 1'b1;
        state_next       = rcp_pkg::S_FINISH;
      end
      rcp_pkg::S_FINISH: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = rcp_pkg::ST_PLACED;
        state_next     = rcp_pkg::S_IDLE;
      end
      default: begin
        state_next = rcp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rcp_datapath.sv =====
module rcp_datapath #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rcp_pkg::cmd_t                         cmd,
  output rcp_pkg::stat_t                        stat,
  input  logic [7:0]                            rect_width,
  input  logic [7:0]                            rect_height,
  input  logic [$clog2(MAX_RECTS + 2)-1:0]      point_index,
  output logic                                  done,
  output logic [2:0]                            status,
  output logic [COORD_BITS-1:0]                 place_x,
  output logic [COORD_BITS-1:0]                 place_y,
  output logic [$clog2(MAX_RECTS + 1)-1:0]      placed_count,
  output logic [$clog2(MAX_RECTS + 2)-1:0]      candidate_count,
  output logic [COORD_BITS-1:0]                 extent_x,
  output logic [COORD_BITS-1:0]                 extent_y
);

  localparam int C          = COORD_BITS;
  localparam int C1         = COORD_BITS + 1;
  localparam int CAND_DEPTH = MAX_RECTS + 1;
  localparam int CAW        = $clog2(CAND_DEPTH);
  localparam int CCW        = $clog2(CAND_DEPTH + 1);
  localparam int RAW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int PCW        = $clog2(MAX_RECTS + 1);
  localparam int RECT_W     = 2 * COORD_BITS + 16;
  localparam int PT_W       = 2 * COORD_BITS;

  // latched item
  logic [7:0]     w_r, h_r;
  logic [CCW-1:0] idx_r;

  // tried point and its far corner
  logic [C-1:0]  px, py;
  logic [C1-1:0] x2, y2, x2_r, y2_r;

  // persistent state
  logic [PCW-1:0] placed_total;
  logic [CCW-1:0] cand_total;
  logic [C-1:0]   ext_x, ext_y;
  logic           origin_live;   // entry 0 still holds the reset origin

  // overlap scan
  logic [PCW-1:0] scan_addr;
  logic           scan_pend, scan_issue;

  // compaction
  logic [CCW-1:0] comp_addr, comp_wa;
  logic           comp_pend, comp_issue;

  // memories
  logic [RECT_W-1:0] rect_rd;
  logic [PT_W-1:0]   cand_rd, cand_wd;
  logic [CAW-1:0]    cand_wa, cand_ra;
  logic              cand_we;
  logic [CCW-1:0]    cand_last;

  logic [C-1:0]  rx, ry;
  logic [C1-1:0] rx2, ry2;
  logic          overlap;

  rcp_ram #(.WIDTH(RECT_W), .DEPTH(MAX_RECTS)) u_rect_ram (
    .clk   (clk),
    .we    (cmd.rect_write),
    .waddr (placed_total[RAW-1:0]),
    .wdata ({px, py, w_r, h_r}),
    .raddr (scan_addr[RAW-1:0]),
    .rdata (rect_rd)
  );

  rcp_ram #(.WIDTH(PT_W), .DEPTH(CAND_DEPTH)) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cand_wa),
    .wdata (cand_wd),
    .raddr (cand_ra),
    .rdata (cand_rd)
  );

  assign x2 = {1'b0, px} + C1'(w_r);
  assign y2 = {1'b0, py} + C1'(h_r);

  assign rx  = rect_rd[RECT_W-1 -: C];
  assign ry  = rect_rd[RECT_W-1-C -: C];
  assign rx2 = {1'b0, rx} + C1'(rect_rd[15:8]);
  assign ry2 = {1'b0, ry} + C1'(rect_rd[7:0]);

  // strict interval overlap: shared edges do not count
  assign overlap = !(({1'b0, px} >= rx2) || ({1'b0, rx} >= x2_r) ||
                     ({1'b0, py} >= ry2) || ({1'b0, ry} >= y2_r));

  assign scan_issue = (scan_addr < placed_total);
  assign comp_issue = (comp_addr < cand_total);
  assign cand_last  = cand_total - CCW'(1);
  assign cand_ra    = cmd.cand_rd_point ? idx_r[CAW-1:0] : comp_addr[CAW-1:0];

  always_comb begin
    cand_we = 1'b0;
    cand_wa = comp_wa[CAW-1:0];
    cand_wd = cand_rd;
    if (cmd.comp_step && comp_pend) begin
      cand_we = 1'b1;
    end else if (cmd.append_top) begin
      cand_we = 1'b1;
      cand_wa = cand_last[CAW-1:0];
      cand_wd = {px, y2_r[C-1:0]};
    end else if (cmd.append_right) begin
      cand_we = 1'b1;
      cand_wa = cand_total[CAW-1:0];
      cand_wd = {x2_r[C-1:0], py};
    end
  end

  assign stat.bad_index = (idx_r >= cand_total);
  assign stat.full      = (placed_total >= PCW'(MAX_RECTS));
  assign stat.overflow  = x2[C] || y2[C];
  assign stat.hit       = scan_pend && overlap;
  assign stat.scan_done = !scan_issue && !scan_pend;
  assign stat.comp_done = !comp_issue && !comp_pend;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w_r   <= rect_width;
      h_r   <= rect_height;
      idx_r <= point_index;
    end
    if (cmd.load_point) begin
      if (idx_r == '0 && origin_live) begin
        px <= '0;
        py <= '0;
      end else begin
        px <= cand_rd[PT_W-1 -: C];
        py <= cand_rd[C-1:0];
      end
    end
    if (cmd.scan_start) begin
      x2_r <= x2;
      y2_r <= y2;
    end
    if (cmd.comp_start) begin
      comp_wa <= idx_r;
    end else if (cmd.comp_step && comp_pend) begin
      comp_wa <= comp_wa + CCW'(1);
    end
    if (cmd.finish) begin
      status          <= cmd.fin_status;
      place_x         <= (cmd.fin_status == rcp_pkg::ST_BAD_INDEX) ? '0 : px;
      place_y         <= (cmd.fin_status == rcp_pkg::ST_BAD_INDEX) ? '0 : py;
      placed_count    <= placed_total;
      candidate_count <= cand_total;
      extent_x        <= ext_x;
      extent_y        <= ext_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed_total <= '0;
      cand_total   <= CCW'(1);
      ext_x        <= '0;
      ext_y        <= '0;
      origin_live  <= 1'b1;
      scan_addr    <= '0;
      scan_pend    <= 1'b0;
      comp_addr    <= '0;
      comp_pend    <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cand_we && cand_wa == '0) begin
        origin_live <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_addr <= '0;
        scan_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_issue) begin
          scan_addr <= scan_addr + PCW'(1);
        end
        scan_pend <= scan_issue;
      end
      if (cmd.comp_start) begin
        comp_addr <= idx_r + CCW'(1);
        comp_pend <= 1'b0;
      end else if (cmd.comp_step) begin
        if (comp_issue) begin
          comp_addr <= comp_addr + CCW'(1);
        end
        comp_pend <= comp_issue;
      end
      if (cmd.append_right) begin
        // one point used, two appended
        cand_total   <= cand_total + CCW'(1);
        placed_total <= placed_total + PCW'(1);
        if (x2_r[C-1:0] > ext_x) begin
          ext_x <= x2_r[C-1:0];
        end
        if (y2_r[C-1:0] > ext_y) begin
          ext_y <= y2_r[C-1:0];
        end
      end
    end
  end

endmodule

// ===== design/rectangle_corner_placement.sv =====
// Rectangle placement at candidate corner points.
//
// Command channel: present rect_width, rect_height and point_index with
// start high; the item is taken at a rising edge where start is high and
// busy is low. busy stays high until the attempt is finished.
// Result channel: done pulses for exactly one cycle with status, place_x,
// place_y, placed_count, candidate_count, extent_x and extent_y valid in
// that cycle. The receiver cannot stall; results must be captured on the
// done cycle. busy is already low during the done cycle, so the next item
// may be issued then.
// An attempt ends in one of four ways: bad index; table full or
// coordinate overflow; overlap with a placed rectangle; or placed.
// Placing an item at index I of the N points held moves the
// M = N - 1 - I points after it down by one place, once the P
// rectangles placed before have all been scanned.
// The overlap scan reads one placed rectangle a cycle and the compaction
// moves one candidate point a cycle.
// Reset (rst, synchronous): no rectangles, extent zero, one candidate point
// at the origin. The stores themselves are not cleared.
module rectangle_corner_placement #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        rect_width,
  input  logic [7:0]                        rect_height,
  input  logic [$clog2(MAX_RECTS + 2)-1:0]  point_index,
  output logic                              done,
  output logic [2:0]                        status,
  output logic [COORD_BITS-1:0]             place_x,
  output logic [COORD_BITS-1:0]             place_y,
  output logic [$clog2(MAX_RECTS + 1)-1:0]  placed_count,
  output logic [$clog2(MAX_RECTS + 2)-1:0]  candidate_count,
  output logic [COORD_BITS-1:0]             extent_x,
  output logic [COORD_BITS-1:0]             extent_y
);

  rcp_pkg::cmd_t  cmd;
  rcp_pkg::stat_t stat;

  // Sequencer: check, fetch point, bounds, overlap scan, compaction,
  // appends, report.
  rcp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Placed-rectangle and candidate-point stores, counters, result register.
  rcp_datapath #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .rect_width      (rect_width),
    .rect_height     (rect_height),
    .point_index     (point_index),
    .done            (done),
    .status          (status),
    .place_x         (place_x),
    .place_y         (place_y),
    .placed_count    (placed_count),
    .candidate_count (candidate_count),
    .extent_x        (extent_x),
    .extent_y        (extent_y)
  );

  // An accepted item always keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // A result pulse only ends a period of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work");

  // The strobe never lasts more than one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // A rejected index reports the origin as the tried point.
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == rcp_pkg::ST_BAD_INDEX) |-> (place_x == '0 && place_y == '0))
    else $error("bad index reported a point");

endmodule
